// ----- rtl/modular_exponentiator_assert.svh -----
// Assertion macros shared by the modular exponentiator RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef MODULAR_EXPONENTIATOR_ASSERT_SVH
`define MODULAR_EXPONENTIATOR_ASSERT_SVH

// Same-cycle implication.
`define MEXP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MEXP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mexp_pkg.sv -----
// Shared types and constants of the modular exponentiator.
// Used by the controller, the datapath and the top level; depends on nothing.
package mexp_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR = CFG_IDX_W'(1);

  localparam logic [WIDTH-1:0] MODULUS_RST   = WIDTH'(2);
  localparam logic [WIDTH-1:0] GENERATOR_RST = WIDTH'(2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MSTART,
    S_DBL,
    S_ADD,
    S_WB,
    S_NEXT,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_REDUCE,
    PH_SQUARE,
    PH_MULT
  } phase_e;

  typedef struct packed {
    logic   load;
    logic   mul_start;
    phase_e sel;
    logic   dbl;
    logic   add;
    logic   wb;
    logic   exp_shift;
    logic   emit;
  } cmd_t;

  typedef struct packed {
    logic mul_last;
    logic exp_bit;
    logic exp_last;
    logic m_small;
  } stat_t;

endpackage

// ----- rtl/mexp_dp.sv -----
// Datapath of the modular exponentiator: operand registers, counters and the
// shared modular adder. Depends on mexp_pkg; driven by mexp_ctrl commands.
module mexp_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mexp_pkg::cmd_t             cmd_i,
  output mexp_pkg::stat_t            stat_o,
  input  logic                       op_i,
  input  logic [mexp_pkg::WIDTH-1:0] peer_key_i,
  input  logic [mexp_pkg::WIDTH-1:0] exponent_i,
  input  logic [mexp_pkg::WIDTH-1:0] modulus_i,
  input  logic [mexp_pkg::WIDTH-1:0] generator_i,
  output logic [mexp_pkg::WIDTH-1:0] result_o
);
  import mexp_pkg::*;

  logic [WIDTH-1:0] base_q, base_d;
  logic [WIDTH-1:0] exp_q, exp_d;
  logic [WIDTH-1:0] res_q, res_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] ma_q, ma_d;
  logic [WIDTH-1:0] mb_q, mb_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] ecnt_q, ecnt_d;

  logic [WIDTH-1:0] add_y;
  logic [WIDTH-1:0] gap;
  logic [WIDTH-1:0] mod_sum;

  // (acc + y) mod m with acc and y below m
  assign add_y   = cmd_i.dbl ? acc_q : ma_q;
  assign gap     = modulus_i - add_y;
  assign mod_sum = (acc_q >= gap) ? (acc_q - gap) : (acc_q + add_y);

  always_comb begin
    base_d = base_q;
    exp_d  = exp_q;
    res_d  = res_q;
    acc_d  = acc_q;
    ma_d   = ma_q;
    mb_d   = mb_q;
    cnt_d  = cnt_q;
    ecnt_d = ecnt_q;
    if (cmd_i.load) begin
      base_d = op_i ? peer_key_i : generator_i;
      exp_d  = exponent_i;
      res_d  = WIDTH'(1);
      ecnt_d = CNT_W'(WIDTH - 1);
    end
    if (cmd_i.mul_start) begin
      acc_d = '0;
      cnt_d = CNT_W'(WIDTH - 1);
      case (cmd_i.sel)
        PH_REDUCE: begin
          ma_d = WIDTH'(1);
          mb_d = base_q;
        end
        PH_SQUARE: begin
          ma_d = res_q;
          mb_d = res_q;
        end
        default: begin
          ma_d = res_q;
          mb_d = base_q;
        end
      endcase
    end
    if (cmd_i.dbl) begin
      acc_d = mod_sum;
    end
    if (cmd_i.add) begin
      if (mb_q[WIDTH-1]) begin
        acc_d = mod_sum;
      end
      mb_d  = {mb_q[WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
    end
    if (cmd_i.wb) begin
      case (cmd_i.sel)
        PH_REDUCE: base_d = acc_q;
        default:   res_d  = acc_q;
      endcase
    end
    if (cmd_i.exp_shift) begin
      exp_d  = {exp_q[WIDTH-2:0], 1'b0};
      ecnt_d = ecnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    exp_q  <= exp_d;
    res_q  <= res_d;
    acc_q  <= acc_d;
    ma_q   <= ma_d;
    mb_q   <= mb_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ecnt_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      ecnt_q <= ecnt_d;
    end
  end

  assign stat_o.mul_last = (cnt_q == '0);
  assign stat_o.exp_bit  = exp_q[WIDTH-1];
  assign stat_o.exp_last = (ecnt_q == '0);
  assign stat_o.m_small  = (modulus_i < WIDTH'(2));

  assign result_o = stat_o.m_small ? '0 : res_q;

endmodule

// ----- rtl/mexp_ctrl.sv -----
// Controller of the modular exponentiator: sequences base reduction, square
// and multiply steps. Depends on mexp_pkg and the assertion macro header.
`include "modular_exponentiator_assert.svh"

module mexp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_free_i,
  input  mexp_pkg::stat_t stat_i,
  output mexp_pkg::cmd_t  cmd_o
);
  import mexp_pkg::*;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_REDUCE;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.sel  = phase_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          phase_d    = PH_REDUCE;
          state_d    = stat_i.m_small ? S_DONE : S_MSTART;
        end
      end
      S_MSTART: begin
        cmd_o.mul_start = 1'b1;
        state_d         = S_DBL;
      end
      S_DBL: begin
        cmd_o.dbl = 1'b1;
        state_d   = S_ADD;
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = stat_i.mul_last ? S_WB : S_DBL;
      end
      S_WB: begin
        cmd_o.wb = 1'b1;
        case (phase_q)
          PH_REDUCE: begin
            phase_d = PH_SQUARE;
            state_d = S_MSTART;
          end
          PH_SQUARE: begin
            if (stat_i.exp_bit) begin
              phase_d = PH_MULT;
              state_d = S_MSTART;
            end else begin
              state_d = S_NEXT;
            end
          end
          default: state_d = S_NEXT;
        endcase
      end
      S_NEXT: begin
        cmd_o.exp_shift = 1'b1;
        phase_d         = PH_SQUARE;
        state_d         = stat_i.exp_last ? S_DONE : S_MSTART;
      end
      S_DONE: begin
        if (out_free_i) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `MEXP_ASSERT_NEXT(a_accept_starts, in_valid_i && in_ready_o, state_q == S_MSTART || state_q == S_DONE, "accepted request did not start")
  `MEXP_ASSERT_IMPL(a_mult_on_set_bit, phase_q == PH_MULT, stat_i.exp_bit, "multiply step on a clear exponent bit")
  `MEXP_ASSERT_NEXT(a_done_holds, state_q == S_DONE && !out_free_i, state_q == S_DONE, "result dropped while output busy")

endmodule

// ----- rtl/modular_exponentiator.sv -----
// Modular exponentiator: returns base^exponent mod modulus, base being the
// configured generator (op 0) or peer_key (op 1), reduced first. One request
// is in work at a time; each exponent bit takes a square step and, if set,
// a multiply step. A modulus of 0 or 1 skips all steps and returns 0.
// The pace is set by the single shared modular adder, which consumes one
// multiplier bit per double step followed by a conditional add step. A finished
// result waits in the output register while the next request is taken.
// Depends on mexp_pkg, mexp_ctrl and mexp_dp.
`include "modular_exponentiator_assert.svh"

module modular_exponentiator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           op_i,
  input  logic [mexp_pkg::WIDTH-1:0]     peer_key_i,
  input  logic [mexp_pkg::WIDTH-1:0]     exponent_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [mexp_pkg::WIDTH-1:0]     result_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mexp_pkg::WIDTH-1:0]     cfg_data_i
);
  import mexp_pkg::*;

  logic [WIDTH-1:0] modulus_q, modulus_d;
  logic [WIDTH-1:0] generator_q, generator_d;
  logic             out_valid_q, out_valid_d;
  logic [WIDTH-1:0] result_q, result_d;
  logic [WIDTH-1:0] dp_result;
  logic             out_free;
  cmd_t             cmd;
  stat_t            stat;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    modulus_d   = modulus_q;
    generator_d = generator_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MODULUS:   modulus_d   = cfg_data_i;
        CFG_GENERATOR: generator_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    result_d    = result_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_d = 1'b1;
      result_d    = dp_result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= MODULUS_RST;
      generator_q <= GENERATOR_RST;
      out_valid_q <= 1'b0;
    end else begin
      modulus_q   <= modulus_d;
      generator_q <= generator_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  mexp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mexp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .op_i        (op_i),
    .peer_key_i  (peer_key_i),
    .exponent_i  (exponent_i),
    .modulus_i   (modulus_q),
    .generator_i (generator_q),
    .result_o    (dp_result)
  );

  `MEXP_ASSERT_IMPL(a_no_overwrite, cmd.emit && out_valid_q, out_ready_i, "pending result overwritten")
  `MEXP_ASSERT_NEXT(a_emit_sets_valid, cmd.emit, out_valid_q, "emitted result not presented")
  `MEXP_ASSERT_IMPL(a_busy_not_ready, out_valid_q && !out_ready_i && cmd.emit, 1'b0, "emit into a stalled output")

endmodule
